// ===== rtl/core/wpb_pkg.sv =====
// ----------------------------------------------------------------------------
// wpb_pkg
// Shared sizes, op codes and inter-module types of the palette blender.
// ----------------------------------------------------------------------------
`default_nettype none

package wpb_pkg;

    localparam int PALETTE_SLOTS = 8;
    localparam int MAX_TERMS     = 4;
    localparam int ENTRIES       = 256;

    localparam int UNITY_WEIGHT  = 256;
    localparam int CHANNEL_MAX   = 255;
    localparam int WEIGHT_SHIFT  = 8;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int WGT_W     = 9;
    localparam int SLOT_W    = 3;
    localparam int PROD_W    = CH_W + WGT_W;
    localparam int ENT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SRC_DEPTH = PALETTE_SLOTS * ENTRIES;
    localparam int SRC_AW    = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
    localparam int TERM_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int ACC_W     = $clog2(MAX_TERMS * UNITY_WEIGHT * CHANNEL_MAX + 1);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_LOAD  = 2'd1,
        OP_BLEND = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // one source read issued by the blend sequencer
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              ok;
        logic [WGT_W-1:0]  weight;
        logic [ENT_W-1:0]  entry;
    } tap_t;

    // write request into the mixed palette
    typedef struct packed {
        logic              we;
        logic [ENT_W-1:0]  addr;
        logic [PIX_W-1:0]  data;
    } mix_wr_t;

    function automatic logic [SRC_AW-1:0] src_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [ENT_W-1:0] e);
        int a;
        a = int'(s) * ENTRIES + int'(e);
        return SRC_AW'(a);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wpb_ram.sv =====
// ----------------------------------------------------------------------------
// wpb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wpb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/wpb_mac.sv =====
// ----------------------------------------------------------------------------
// wpb_mac
// Weight multiply, per-entry accumulate and saturate for the three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module wpb_mac (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wpb_pkg::tap_t     tap,
    input  wire logic [wpb_pkg::PIX_W-1:0] rdata,
    output wpb_pkg::mix_wr_t       wr,
    output logic                   busy
);
    import wpb_pkg::*;

    tap_t              s2_reg;
    tap_t              s2_next;
    logic [PROD_W-1:0] prod_reg [3];
    logic [PROD_W-1:0] prod_next [3];
    logic [ACC_W-1:0]  acc_reg [3];
    logic [ACC_W-1:0]  acc_next [3];
    logic [ACC_W-1:0]  acc_sum [3];
    logic [ACC_W-1:0]  shifted [3];
    logic [CH_W-1:0]   chan [3];

    always_comb
    begin
        s2_next = tap;
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c] = tap.ok
                ? PROD_W'(PROD_W'(tap.weight) * PROD_W'(rdata[c*CH_W +: CH_W]))
                : '0;
            acc_sum[c]   = (s2_reg.first ? '0 : acc_reg[c]) + ACC_W'(prod_reg[c]);
            acc_next[c]  = s2_reg.valid ? acc_sum[c] : acc_reg[c];
            shifted[c]   = acc_sum[c] >> WEIGHT_SHIFT;
            chan[c]      = (shifted[c] > ACC_W'(CHANNEL_MAX)) ? CH_W'(CHANNEL_MAX)
                                                              : shifted[c][CH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= prod_next[c];
            acc_reg[c]  <= acc_next[c];
        end
    end

    // channel order red, green, blue from the top bits down
    assign wr.we   = s2_reg.valid && s2_reg.last;
    assign wr.addr = s2_reg.entry;
    assign wr.data = {chan[2], chan[1], chan[0]};
    assign busy    = s2_reg.valid;

endmodule

`default_nettype wire

// ===== rtl/core/weighted_palette_blend.sv =====
// ----------------------------------------------------------------------------
// weighted_palette_blend
// Source palettes and a mixed palette in RAM, blended by a term sequencer.
// ----------------------------------------------------------------------------
// short ops: write, term load and read give their result beat through the
//   pending and output registers; taken one per cycle while no result stalls
// blend: one source RAM read per cycle, ENTRIES * max(used terms, 1) in all,
//   then a MAC drain; the result beat follows and the next item is taken in idle
// reset: clears the control registers; a clearing pass that zeroes both RAMs
//   runs first, with item_stall held high
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_palette_blend (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic [1:0]                   op,
    input  wire logic [wpb_pkg::SLOT_W-1:0]   slot,
    input  wire logic [7:0]                   index,
    input  wire logic [7:0]                   red,
    input  wire logic [7:0]                   green,
    input  wire logic [7:0]                   blue,
    input  wire logic [wpb_pkg::WGT_W-1:0]    weight,
    input  wire logic [2:0]                   term_count,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [7:0]                        out_red,
    output logic [7:0]                        out_green,
    output logic [7:0]                        out_blue,
    output logic                              blend_done
);
    import wpb_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic read_ok;
        logic is_blend;
    } pend_t;

    state_t            state_reg, state_next;
    logic [SRC_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ENT_W-1:0]  e_cnt_reg, e_cnt_next;
    logic [TERM_W-1:0] t_cnt_reg, t_cnt_next;
    logic [TERM_W-1:0] last_t_reg, last_t_next;
    logic              zero_reg, zero_next;
    tap_t              s1_reg, s1_next;
    logic [SLOT_W-1:0] term_slot_reg [MAX_TERMS];
    logic [SLOT_W-1:0] term_slot_next [MAX_TERMS];
    logic [WGT_W-1:0]  term_wgt_reg [MAX_TERMS];
    logic [WGT_W-1:0]  term_wgt_next [MAX_TERMS];
    pend_t             pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   out_red_reg, out_red_next;
    logic [CH_W-1:0]   out_green_reg, out_green_next;
    logic [CH_W-1:0]   out_blue_reg, out_blue_next;
    logic              blend_done_reg, blend_done_next;

    logic              out_free;
    logic              pend_move;
    logic              pend_free;
    logic              accept;
    op_t               op_code;
    logic [CNT_W-1:0]  used;
    logic [SLOT_W-1:0] cur_slot;
    logic              cur_ok;

    logic              src_we;
    logic [SRC_AW-1:0] src_waddr;
    logic [PIX_W-1:0]  src_wdata;
    logic              src_re;
    logic [SRC_AW-1:0] src_raddr;
    logic [PIX_W-1:0]  src_rdata;

    logic              mix_we;
    logic [ENT_W-1:0]  mix_waddr;
    logic [PIX_W-1:0]  mix_wdata;
    logic              mix_re;
    logic [PIX_W-1:0]  mix_rdata;

    mix_wr_t           mac_wr;
    logic              mac_busy;

    assign op_code   = op_t'(op);
    assign out_free  = !out_valid_reg || !result_stall;
    assign pend_move = pend_reg.valid && out_free;
    assign pend_free = !pend_reg.valid || out_free;
    assign item_stall = !((state_reg == ST_IDLE) && pend_free);
    assign accept    = item_valid && !item_stall;

    assign used     = (int'(term_count) > MAX_TERMS) ? CNT_W'(MAX_TERMS)
                                                     : CNT_W'(term_count);
    assign cur_ok   = (int'(term_slot_reg[t_cnt_reg]) < PALETTE_SLOTS) && !zero_reg;
    assign cur_slot = cur_ok ? term_slot_reg[t_cnt_reg] : '0;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        e_cnt_next      = e_cnt_reg;
        t_cnt_next      = t_cnt_reg;
        last_t_next     = last_t_reg;
        zero_next       = zero_reg;
        s1_next         = '0;
        term_slot_next  = term_slot_reg;
        term_wgt_next   = term_wgt_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_red_next    = out_red_reg;
        out_green_next  = out_green_reg;
        out_blue_next   = out_blue_reg;
        blend_done_next = blend_done_reg;

        if (pend_move)
        begin
            out_valid_next  = 1'b1;
            out_red_next    = pend_reg.read_ok ? mix_rdata[2*CH_W +: CH_W] : '0;
            out_green_next  = pend_reg.read_ok ? mix_rdata[CH_W +: CH_W] : '0;
            out_blue_next   = pend_reg.read_ok ? mix_rdata[0 +: CH_W] : '0;
            blend_done_next = pend_reg.is_blend;
            pend_next.valid = 1'b0;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SRC_AW'(SRC_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_code == OP_BLEND)
                    begin
                        state_next  = ST_ISSUE;
                        e_cnt_next  = '0;
                        t_cnt_next  = '0;
                        zero_next   = (used == '0);
                        last_t_next = (used == '0) ? '0 : TERM_W'(used - 1'b1);
                    end
                    else
                    begin
                        pend_next.valid    = 1'b1;
                        pend_next.is_blend = 1'b0;
                        pend_next.read_ok  = (op_code == OP_READ) &&
                                             (int'(index) < ENTRIES);
                    end
                    if ((op_code == OP_LOAD) && (int'(index) < MAX_TERMS))
                    begin
                        term_slot_next[TERM_W'(index)] = slot;
                        term_wgt_next[TERM_W'(index)]  =
                            (int'(weight) > UNITY_WEIGHT) ? WGT_W'(UNITY_WEIGHT) : weight;
                    end
                end
            end
            ST_ISSUE:
            begin
                s1_next.valid  = 1'b1;
                s1_next.first  = (t_cnt_reg == '0);
                s1_next.last   = (t_cnt_reg == last_t_reg);
                s1_next.ok     = cur_ok;
                s1_next.weight = term_wgt_reg[t_cnt_reg];
                s1_next.entry  = e_cnt_reg;
                if (t_cnt_reg == last_t_reg)
                begin
                    t_cnt_next = '0;
                    e_cnt_next = e_cnt_reg + 1'b1;
                    if (e_cnt_reg == ENT_W'(ENTRIES - 1))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    t_cnt_next = t_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_reg.valid && !mac_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (pend_free)
                begin
                    pend_next.valid    = 1'b1;
                    pend_next.is_blend = 1'b1;
                    pend_next.read_ok  = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            e_cnt_reg      <= '0;
            t_cnt_reg      <= '0;
            last_t_reg     <= '0;
            zero_reg       <= 1'b0;
            s1_reg         <= '0;
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                term_slot_reg[i] <= '0;
                term_wgt_reg[i]  <= '0;
            end
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_red_reg    <= '0;
            out_green_reg  <= '0;
            out_blue_reg   <= '0;
            blend_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            e_cnt_reg      <= e_cnt_next;
            t_cnt_reg      <= t_cnt_next;
            last_t_reg     <= last_t_next;
            zero_reg       <= zero_next;
            s1_reg         <= s1_next;
            term_slot_reg  <= term_slot_next;
            term_wgt_reg   <= term_wgt_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_red_reg    <= out_red_next;
            out_green_reg  <= out_green_next;
            out_blue_reg   <= out_blue_next;
            blend_done_reg <= blend_done_next;
        end
    end

    // source palette ports
    assign src_we    = (state_reg == ST_CLEAR) ||
                       (accept && (op_code == OP_WRITE) &&
                        (int'(slot) < PALETTE_SLOTS) && (int'(index) < ENTRIES));
    assign src_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg
                                               : src_addr(slot, ENT_W'(index));
    assign src_wdata = (state_reg == ST_CLEAR) ? '0 : {red, green, blue};
    assign src_re    = (state_reg == ST_ISSUE);
    assign src_raddr = src_addr(cur_slot, e_cnt_reg);

    // mixed palette ports
    assign mix_we    = (state_reg == ST_CLEAR) || mac_wr.we;
    assign mix_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg[ENT_W-1:0] : mac_wr.addr;
    assign mix_wdata = (state_reg == ST_CLEAR) ? '0 : mac_wr.data;
    assign mix_re    = accept && (op_code == OP_READ);

    wpb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SRC_DEPTH)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (src_waddr),
        .wdata (src_wdata),
        .re    (src_re),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    wpb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (ENTRIES)
    ) u_mix_ram (
        .clk   (clk),
        .we    (mix_we),
        .waddr (mix_waddr),
        .wdata (mix_wdata),
        .re    (mix_re),
        .raddr (ENT_W'(index)),
        .rdata (mix_rdata)
    );

    wpb_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .tap   (s1_reg),
        .rdata (src_rdata),
        .wr    (mac_wr),
        .busy  (mac_busy)
    );

    assign result_valid = out_valid_reg;
    assign out_red      = out_red_reg;
    assign out_green    = out_green_reg;
    assign out_blue     = out_blue_reg;
    assign blend_done   = blend_done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/wpb_checker.sv =====
// ----------------------------------------------------------------------------
// wpb_checker
// Port-level checks of the palette blender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wpb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic [1:0] op,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] out_red,
    input wire logic [7:0] out_green,
    input wire logic [7:0] out_blue,
    input wire logic       blend_done
);
    import wpb_pkg::*;

    // blend beat carries no color
    a_blend_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && blend_done) |->
            (out_red == '0 && out_green == '0 && out_blue == '0))
        else $error("blend beat with nonzero color");

    // a blend holds off the next item
    a_blend_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && op == OP_BLEND) |=> item_stall)
        else $error("item taken right after blend");

    // after a short op, stall only while a result waits
    a_short_op_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && op != OP_BLEND) |=> (result_valid || !item_stall))
        else $error("stall with no result pending");

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(out_red) && $stable(out_green) &&
             $stable(out_blue) && $stable(blend_done)))
        else $error("stalled result changed");

endmodule

bind weighted_palette_blend wpb_checker u_wpb_checker (.*);

`default_nettype wire
